// ===== rtl/bitfs_pkg.sv =====
// Shared constants, codes and word types for the busy interval table.
`default_nettype none
package bitfs_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int TIME_BITS   = 16;

   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int SLOT_W = TIME_BITS + 2;
   localparam int ENTRY_W = 2 * TIME_BITS;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_QUERY  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STAT_ADDED     = 2'd0,
      STAT_DUPLICATE = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_ANSWERED  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      op_type                 op;
      logic [TIME_BITS-1:0]   start_time;
      logic [TIME_BITS-1:0]   end_time;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic                   is_free;
      logic [TIME_BITS-1:0]   next_start;
      logic [TIME_BITS-1:0]   next_end;
      logic                   overflow;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic step;
   } eval_ctl_type;

   typedef struct packed {
      logic                   is_free;
      logic [TIME_BITS-1:0]   next_start;
      logic [TIME_BITS-1:0]   next_end;
      logic                   overflow;
      logic                   dup;
   } eval_res_type;

endpackage
`default_nettype wire

// ===== rtl/bitfs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bitfs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic                                      rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== rtl/bitfs_eval.sv =====
// Per-entry compare and slot update datapath for the table scan.
`default_nettype none
module bitfs_eval (
   input  wire logic                                clock,
   input  wire bitfs_pkg::eval_ctl_type             ctl,
   input  wire logic [bitfs_pkg::TIME_BITS-1:0]     load_start,
   input  wire logic [bitfs_pkg::TIME_BITS-1:0]     load_end,
   input  wire logic [bitfs_pkg::TIME_BITS-1:0]     entry_start,
   input  wire logic [bitfs_pkg::TIME_BITS-1:0]     entry_end,
   output bitfs_pkg::eval_res_type                  res
);
   localparam int TB = bitfs_pkg::TIME_BITS;
   localparam int SW = bitfs_pkg::SLOT_W;
   localparam logic signed [SW-1:0] MAX_SLOT = signed'({2'b00, {TB{1'b1}}});

   logic [TB-1:0]        qs_ff, qs_in;
   logic [TB-1:0]        qe_ff, qe_in;
   logic [TB-1:0]        cs_ff, cs_in;
   logic signed [SW-1:0] ce_ff, ce_in;
   logic signed [SW-1:0] len_ff, len_in;
   logic                 free_ff, free_in;
   logic                 dup_ff, dup_in;

   logic signed [SW-1:0] bs_x, be_x;
   logic                 touch_q, touch_c;

   always_comb begin
      bs_x = signed'({2'b00, entry_start});
      be_x = signed'({2'b00, entry_end});
      // query span against stored entry
      touch_q = (qs_ff >= entry_start && qs_ff < entry_end) ||
                (entry_start >= qs_ff && entry_start < qe_ff);
      // moving slot against stored entry, slot end kept exact
      touch_c = (cs_ff >= entry_start && cs_ff < entry_end) ||
                (entry_start >= cs_ff && bs_x < ce_ff);

      qs_in   = qs_ff;
      qe_in   = qe_ff;
      cs_in   = cs_ff;
      ce_in   = ce_ff;
      len_in  = len_ff;
      free_in = free_ff;
      dup_in  = dup_ff;

      if (ctl.load) begin
         qs_in   = load_start;
         qe_in   = load_end;
         cs_in   = load_start;
         ce_in   = signed'({2'b00, load_end});
         len_in  = signed'({2'b00, load_end}) - signed'({2'b00, load_start});
         free_in = 1'b1;
         dup_in  = 1'b0;
      end else if (ctl.step) begin
         if (touch_q) begin
            free_in = 1'b0;
         end
         if (touch_c) begin
            cs_in = entry_end;
            ce_in = be_x + len_ff;
         end
         if (entry_start == qs_ff && entry_end == qe_ff) begin
            dup_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      qs_ff   <= qs_in;
      qe_ff   <= qe_in;
      cs_ff   <= cs_in;
      ce_ff   <= ce_in;
      len_ff  <= len_in;
      free_ff <= free_in;
      dup_ff  <= dup_in;
   end

   // saturate the final slot end
   always_comb begin
      res.is_free    = free_ff;
      res.next_start = cs_ff;
      res.dup        = dup_ff;
      if (ce_ff > MAX_SLOT) begin
         res.next_end = {TB{1'b1}};
         res.overflow = 1'b1;
      end else if (ce_ff < 0) begin
         res.next_end = '0;
         res.overflow = 1'b0;
      end else begin
         res.next_end = ce_ff[TB-1:0];
         res.overflow = 1'b0;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/busy_interval_table_free_slot.sv =====
// Top level: busy interval table with duplicate check and free slot search.
// A new request is taken only in idle, after the previous response has been registered.
// The scan reads one table entry per cycle from the single read port of the memory;
//   a response left waiting on rsp_ready stalls the next word in its finish step.
// Reset clears the entry count and control state; the interval memory is not cleared.
`default_nettype none
module busy_interval_table_free_slot (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire bitfs_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output bitfs_pkg::rsp_type     rsp_data
);
   localparam int TB = bitfs_pkg::TIME_BITS;
   localparam int CW = bitfs_pkg::CNT_W;
   localparam int AW = bitfs_pkg::ADDR_W;
   localparam logic [CW-1:0] MAX_CNT = CW'(bitfs_pkg::MAX_ENTRIES);

   // sequencer state
   bitfs_pkg::state_type state_ff, state_in;
   logic [CW-1:0]        rd_idx_ff, rd_idx_in;
   logic                 pend_ff, pend_in;
   bitfs_pkg::op_type    op_ff, op_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   bitfs_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   // hold the request interval for the append at the end of an insert
   logic [TB-1:0] ins_start_ff, ins_start_in;
   logic [TB-1:0] ins_end_ff, ins_end_in;

   // memory and datapath hookup
   logic                          rd_en, wr_en;
   logic [bitfs_pkg::ENTRY_W-1:0] rd_word, wr_word;
   bitfs_pkg::eval_ctl_type       ctl;
   bitfs_pkg::eval_res_type       res;

   assign wr_word = {ins_start_ff, ins_end_ff};

   // interval memory: {start, end} per entry, appended in insertion order
   bitfs_ram #(
      .WIDTH (bitfs_pkg::ENTRY_W),
      .DEPTH (bitfs_pkg::MAX_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_word),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (rd_word)
   );

   bitfs_eval u_eval (
      .clock       (clock),
      .ctl         (ctl),
      .load_start  (req_data.start_time),
      .load_end    (req_data.end_time),
      .entry_start (rd_word[2*TB-1:TB]),
      .entry_end   (rd_word[TB-1:0]),
      .res         (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bitfs_pkg::ST_IDLE;
         rd_idx_ff    <= '0;
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_idx_ff    <= rd_idx_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      ins_start_ff <= ins_start_in;
      ins_end_ff   <= ins_end_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      rd_idx_in    = rd_idx_ff;
      pend_in      = pend_ff;
      op_in        = op_ff;
      count_in     = count_ff;
      ins_start_in = ins_start_ff;
      ins_end_in   = ins_end_ff;
      rsp_data_in  = rsp_data_ff;
      // drop the response word once taken
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      req_ready    = 1'b0;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      ctl.load     = 1'b0;
      ctl.step     = 1'b0;

      unique case (state_ff)
         bitfs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               // capture the word and restart the scan
               ctl.load     = 1'b1;
               op_in        = req_data.op;
               ins_start_in = req_data.start_time;
               ins_end_in   = req_data.end_time;
               rd_idx_in    = '0;
               pend_in      = 1'b0;
               state_in     = bitfs_pkg::ST_SCAN;
            end
         end
         bitfs_pkg::ST_SCAN: begin
            // evaluate the entry read last cycle
            ctl.step = pend_ff;
            if (rd_idx_ff < count_ff) begin
               // advance the read pointer, one entry per cycle
               rd_en     = 1'b1;
               rd_idx_in = rd_idx_ff + 1'b1;
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = bitfs_pkg::ST_FINISH;
               end
            end
         end
         bitfs_pkg::ST_FINISH: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (op_ff == bitfs_pkg::OP_QUERY) begin
                  rsp_data_in.status     = bitfs_pkg::STAT_ANSWERED;
                  rsp_data_in.is_free    = res.is_free;
                  rsp_data_in.next_start = res.next_start;
                  rsp_data_in.next_end   = res.next_end;
                  rsp_data_in.overflow   = res.overflow;
               end else begin
                  rsp_data_in.is_free    = 1'b0;
                  rsp_data_in.next_start = '0;
                  rsp_data_in.next_end   = '0;
                  rsp_data_in.overflow   = 1'b0;
                  if (res.dup) begin
                     rsp_data_in.status = bitfs_pkg::STAT_DUPLICATE;
                  end else if (count_ff >= MAX_CNT) begin
                     rsp_data_in.status = bitfs_pkg::STAT_FULL;
                  end else begin
                     // append at the tail, ahead of any later scan read
                     rsp_data_in.status = bitfs_pkg::STAT_ADDED;
                     wr_en              = 1'b1;
                     count_in           = count_ff + 1'b1;
                  end
               end
               state_in = bitfs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bitfs_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // table never grows past its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("entry count beyond table depth");

   // an append only happens with room left and outside the scan
   a_write_room: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (count_ff < MAX_CNT) && (state_ff == bitfs_pkg::ST_FINISH))
      else $error("append without room or outside finish");

   // read pointer never passes the entry count during the scan
   a_rd_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bitfs_pkg::ST_SCAN) |-> (rd_idx_ff <= count_ff))
      else $error("scan read pointer past entry count");

   // a pending evaluation always follows a memory read
   a_pend_read: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(rd_en))
      else $error("evaluation without a preceding read");
endmodule
`default_nettype wire
